@@ rtl/keypad_code_entry_lock_assert.svh @@
// ----------------------------------------------------------------------------
// Keypad code entry lock: assertion macros
// Shared concurrent assertion forms for the lock's checker.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_ENTRY_LOCK_ASSERT_SVH
`define KEYPAD_CODE_ENTRY_LOCK_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define KCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kcl assertion failed");

// next-cycle implication, disabled while reset is low
`define KCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kcl assertion failed");

`endif

@@ rtl/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad code entry lock: package
// Types, codes and helper functions shared by the lock modules.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int CODE_LENGTH = 8;
    localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int COUNT_W     = 4;
    localparam int KEY_W       = 4;
    localparam int IDLE_W      = 10;
    localparam int CODE_W      = 32;
    localparam int NIB_COUNT   = CODE_W / KEY_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CODE_W-1:0] STORED_CODE_RST = 32'hFFFF_FFFF;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST  = 10'd150;

    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CANCEL    = 4'd12;
    localparam logic [KEY_W-1:0] KEY_ERASE     = 4'd13;
    localparam logic [KEY_W-1:0] KEY_HASH      = 4'd15;

    typedef enum logic {
        CMD_KEY  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STORED_CODE = 1'b0,
        CFG_IDLE_LIMIT  = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_CANCEL   = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_MATCH    = 3'd4,
        ST_MISMATCH = 3'd5
    } t_status;

    typedef struct packed {
        logic [CODE_W-1:0] stored_code;
        logic [IDLE_W-1:0] idle_limit;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] entered_count;
    } t_result;

    // nibble expected at a code position; positions past the stored word read as hash
    function automatic logic [KEY_W-1:0] code_nibble(input logic [CODE_W-1:0] code,
                                                     input int unsigned pos);
        logic [KEY_W-1:0] nib;
        nib = KEY_HASH;
        if (pos < NIB_COUNT) begin
            nib = code[(NIB_COUNT - 1 - pos) * KEY_W +: KEY_W];
        end
        return nib;
    endfunction

endpackage

@@ rtl/kcl_cfg.sv @@
// ----------------------------------------------------------------------------
// Keypad code entry lock: configuration registers
// Holds the stored code and the idle limit, written through the plain port.
// ----------------------------------------------------------------------------
module kcl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kcl_pkg::CODE_W-1:0]    i_cfg_data,
    output kcl_pkg::t_cfg                 o_cfg
);

    logic [kcl_pkg::CODE_W-1:0] r_stored_code;
    logic [kcl_pkg::IDLE_W-1:0] r_idle_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_code <= kcl_pkg::STORED_CODE_RST;
            r_idle_limit  <= kcl_pkg::IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (kcl_pkg::t_cfg_reg'(i_cfg_idx))
                kcl_pkg::CFG_STORED_CODE: begin
                    r_stored_code <= i_cfg_data;
                end
                kcl_pkg::CFG_IDLE_LIMIT: begin
                    r_idle_limit <= i_cfg_data[kcl_pkg::IDLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.stored_code = r_stored_code;
    assign o_cfg.idle_limit  = r_idle_limit;

endmodule

@@ rtl/kcl_core.sv @@
// ----------------------------------------------------------------------------
// Keypad code entry lock: session core
// Code buffer, entry index and idle counter; one key or tick per transaction.
// ----------------------------------------------------------------------------
module kcl_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kcl_pkg::t_cfg             i_cfg,
    input  logic                      i_accept,
    input  logic                      i_cmd,
    input  logic [kcl_pkg::KEY_W-1:0] i_key,
    output kcl_pkg::t_result          o_result
);

    localparam logic [kcl_pkg::IDX_W-1:0] LAST_IDX = kcl_pkg::IDX_W'(kcl_pkg::CODE_LENGTH - 1);

    logic [kcl_pkg::KEY_W-1:0]  r_code_buf [kcl_pkg::CODE_LENGTH];
    logic [kcl_pkg::IDX_W-1:0]  r_entry_idx;
    logic [kcl_pkg::IDLE_W-1:0] r_idle_cnt;

    logic [kcl_pkg::IDX_W-1:0]  n_entry_idx;
    logic [kcl_pkg::IDLE_W-1:0] n_idle_cnt;
    logic [kcl_pkg::IDLE_W:0]   idle_inc;
    logic                       is_entry;
    logic                       buf_we;
    logic                       code_ok;
    logic [kcl_pkg::KEY_W-1:0]  cmp_nib;
    kcl_pkg::t_status           status;

    assign is_entry = (i_key <= kcl_pkg::KEY_DIGIT_MAX) || (i_key == kcl_pkg::KEY_HASH);
    assign idle_inc = {1'b0, r_idle_cnt} + (kcl_pkg::IDLE_W + 1)'(1);

    // the final entry joins the compare straight from the key
    always_comb begin
        code_ok = 1'b1;
        cmp_nib = '0;
        for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
            cmp_nib = (i == kcl_pkg::CODE_LENGTH - 1) ? i_key : r_code_buf[i];
            if (cmp_nib != kcl_pkg::code_nibble(i_cfg.stored_code, i)) begin
                code_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_entry_idx = r_entry_idx;
        n_idle_cnt  = r_idle_cnt;
        buf_we      = 1'b0;
        status      = kcl_pkg::ST_PROGRESS;
        if (kcl_pkg::t_cmd'(i_cmd) == kcl_pkg::CMD_TICK) begin
            if (idle_inc > {1'b0, i_cfg.idle_limit}) begin
                n_entry_idx = '0;
                n_idle_cnt  = '0;
                status      = kcl_pkg::ST_TIMEOUT;
            end else begin
                n_idle_cnt = idle_inc[kcl_pkg::IDLE_W-1:0];
            end
        end else if (is_entry) begin
            n_idle_cnt = '0;
            buf_we     = 1'b1;
            if (r_entry_idx == LAST_IDX) begin
                n_entry_idx = '0;
                status      = code_ok ? kcl_pkg::ST_MATCH : kcl_pkg::ST_MISMATCH;
            end else begin
                n_entry_idx = r_entry_idx + kcl_pkg::IDX_W'(1);
            end
        end else if (i_key == kcl_pkg::KEY_ERASE) begin
            n_idle_cnt = '0;
            // erase at the first position leaves the index alone
            if (r_entry_idx != '0) begin
                n_entry_idx = r_entry_idx - kcl_pkg::IDX_W'(1);
            end
        end else if (i_key == kcl_pkg::KEY_CANCEL) begin
            n_entry_idx = '0;
            n_idle_cnt  = '0;
            status      = kcl_pkg::ST_CANCEL;
        end else begin
            status = kcl_pkg::ST_IGNORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_idx <= '0;
            r_idle_cnt  <= '0;
        end else if (i_accept) begin
            r_entry_idx <= n_entry_idx;
            r_idle_cnt  <= n_idle_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && buf_we) begin
            r_code_buf[r_entry_idx] <= i_key;
        end
    end

    assign o_result.status        = status;
    assign o_result.entered_count = kcl_pkg::COUNT_W'(n_entry_idx);

endmodule

@@ rtl/kcl_out.sv @@
// ----------------------------------------------------------------------------
// Keypad code entry lock: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module kcl_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  kcl_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output kcl_pkg::t_result o_result,
    output logic             o_space
);

    logic             r_valid;
    kcl_pkg::t_result r_result;

    // accept when empty or when the held result leaves this cycle
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/keypad_code_entry_lock.sv @@
// ----------------------------------------------------------------------------
// Keypad code entry lock
// Collects keypad entries and time ticks, reports cancel, timeout and the
// outcome of the code compare once the buffer is full.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tuser: cmd [0]; tdata: key_code [3:0], zero [7:4]
// m_axis    out        tdata: status [2:0], entered_count [6:3], zero [7]
// i_cfg     in         idx 0 stored_code (32 bits), idx 1 idle_limit (10 bits)
//
// One transaction per cycle while s_axis_tready is high; each result appears
// in the cycle after its input is accepted, from the single result register.
// s_axis_tready stays high while the register is empty or being emptied.
// Synchronous active-low reset clears the session and restores the registers.
// ----------------------------------------------------------------------------
module keypad_code_entry_lock (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kcl_pkg::CODE_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // key_code [3:0], zero [7:4]
    input  logic                          s_axis_tuser,  // cmd [0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata   // status [2:0], count [6:3], zero [7]
);

    kcl_pkg::t_cfg    cfg;
    kcl_pkg::t_result core_result;
    kcl_pkg::t_result out_result;
    logic             in_accept;
    logic             out_space;

    assign in_accept     = s_axis_tvalid && out_space;
    assign s_axis_tready = out_space;

    kcl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    kcl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (in_accept),
        .i_cmd    (s_axis_tuser),
        .i_key    (s_axis_tdata[kcl_pkg::KEY_W-1:0]),
        .o_result (core_result)
    );

    kcl_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result),
        .o_space  (out_space)
    );

    assign m_axis_tdata = {1'b0, out_result.entered_count, out_result.status};

endmodule

@@ rtl/kcl_checker.sv @@
// ----------------------------------------------------------------------------
// Keypad code entry lock: port checker
// Watches the lock's ports for result and flow-control slips.
// ----------------------------------------------------------------------------
`include "keypad_code_entry_lock_assert.svh"

module kcl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic       ended;
    logic [3:0] count;

    assign count = m_axis_tdata[6:3];
    assign ended = (m_axis_tdata[2:0] == kcl_pkg::ST_CANCEL)
                || (m_axis_tdata[2:0] == kcl_pkg::ST_TIMEOUT)
                || (m_axis_tdata[2:0] == kcl_pkg::ST_MATCH)
                || (m_axis_tdata[2:0] == kcl_pkg::ST_MISMATCH);

    // a stalled result stays on offer
    `KCL_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // every accepted transaction gives a result in the next cycle
    `KCL_ASSERT_NEXT(a_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    // a finished session reports an empty buffer
    `KCL_ASSERT_IMPL(a_end_empty, i_clk, i_rst_n, m_axis_tvalid && ended, count == 4'd0)
    // the buffer never reports itself full; a full buffer ends the session
    `KCL_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, m_axis_tvalid, count < 4'(kcl_pkg::CODE_LENGTH))
    // an empty result register never blocks the input
    `KCL_ASSERT_IMPL(a_no_block, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind keypad_code_entry_lock kcl_checker u_kcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/keypad_lock_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code entry lock: result checker
// Follows the configuration port and both stream channels, works out the
// status and entry count that each accepted key or tick must produce, and
// compares every result transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module keypad_lock_checker
    import kcl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CODE_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // key_code [3:0], zero [7:4]
    input  logic                 s_axis_tuser,  // cmd [0]
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,  // status [2:0], entered_count [6:3], zero [7]
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [CODE_W-1:0] code_reg;
    logic [IDLE_W-1:0] limit_reg;
    logic [KEY_W-1:0]  entries [CODE_LENGTH];
    int unsigned       entry_idx;
    logic [IDLE_W-1:0] idle_cnt;
    t_result           pending_results [$];
    int                fails;
    int                outstanding;

    assign o_fail_count = fails;
    assign o_pending    = outstanding;

    function automatic t_result next_lock_result(t_cmd cmd, logic [KEY_W-1:0] key);
        t_result         res;
        logic [IDLE_W:0] nxt;
        logic [KEY_W-1:0] want_nib;
        bit              same;
        res.status = ST_PROGRESS;
        if (cmd == CMD_TICK) begin
            // one bit wider so that the largest limit never wraps
            nxt = {1'b0, idle_cnt} + 1'b1;
            if (nxt > {1'b0, limit_reg}) begin
                entry_idx  = 0;
                idle_cnt   = '0;
                res.status = ST_TIMEOUT;
            end else begin
                idle_cnt = nxt[IDLE_W-1:0];
            end
        end else if (key <= KEY_DIGIT_MAX || key == KEY_HASH) begin
            idle_cnt = '0;
            if (entry_idx < CODE_LENGTH) begin
                entries[entry_idx] = key;
            end
            entry_idx++;
            if (entry_idx >= CODE_LENGTH) begin
                same = 1'b1;
                for (int i = 0; i < CODE_LENGTH; i++) begin
                    want_nib = (i < NIB_COUNT) ? code_reg[(NIB_COUNT - 1 - i) * KEY_W +: KEY_W]
                                               : KEY_HASH;
                    if (entries[i] != want_nib) begin
                        same = 1'b0;
                    end
                end
                res.status = same ? ST_MATCH : ST_MISMATCH;
                entry_idx  = 0;
                idle_cnt   = '0;
            end
        end else if (key == KEY_ERASE) begin
            // erase at position zero still counts as activity
            idle_cnt = '0;
            if (entry_idx > 0) begin
                entry_idx--;
            end
        end else if (key == KEY_CANCEL) begin
            entry_idx  = 0;
            idle_cnt   = '0;
            res.status = ST_CANCEL;
        end else begin
            res.status = ST_IGNORED;
        end
        res.entered_count = entry_idx[COUNT_W-1:0];
        return res;
    endfunction

    initial begin
        fails       = 0;
        outstanding = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            code_reg  = STORED_CODE_RST;
            limit_reg = IDLE_LIMIT_RST;
            entry_idx = 0;
            idle_cnt  = '0;
            pending_results.delete();
        end else begin
            // retire the older result first: it belongs to an earlier transaction
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing outstanding: status %0d, entered_count %0d",
                           m_axis_tdata[2:0], m_axis_tdata[6:3]);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[2:0] != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
                        fails++;
                    end
                    if (m_axis_tdata[6:3] != want.entered_count) begin
                        $error("entered_count: expected %0d, got %0d",
                               want.entered_count, m_axis_tdata[6:3]);
                        fails++;
                    end
                    if (m_axis_tdata[7] !== 1'b0) begin
                        $error("pad: expected 0, got %0b", m_axis_tdata[7]);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(next_lock_result(t_cmd'(s_axis_tuser),
                                                           s_axis_tdata[KEY_W-1:0]));
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_STORED_CODE: code_reg  = i_cfg_data;
                    CFG_IDLE_LIMIT:  limit_reg = i_cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = pending_results.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code entry lock: testbench
// Drives key and tick events with random gaps and back-pressure through a
// series of code and idle-limit settings, including a tick run up to the
// idle abort; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb;
    import kcl_pkg::*;

    localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
    localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
    localparam int               HOLD_CYCLES = 60;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CODE_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;  // key_code [3:0], zero [7:4]
    logic                 s_axis_tuser  = 1'b0;  // cmd [0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;  // status [2:0], entered_count [6:3], zero [7]

    int fail_count;
    int pending;
    int n_sent     = 0;
    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;
    bit rx_hold_req = 1'b0;
    int unsigned phase_limits [10] = '{1, 2, 3, 5, 8, 0, 1000, 4, 1, 6};

    always #5 i_clk = ~i_clk;

    keypad_code_entry_lock uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    keypad_lock_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result sink: random stalls, a quiet mode and one long hold-off on request
    initial begin : result_sink
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt != 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_cnt    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= rx_quiet || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("keypad_code_entry_lock regression: fail");
        $finish;
    end

    function automatic logic [KEY_W-1:0] rand_code_key();
        return ($urandom_range(0, 10) == 10) ? KEY_HASH : KEY_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CODE_W-1:0] rand_valid_code();
        logic [CODE_W-1:0] c;
        c = '0;
        for (int i = 0; i < NIB_COUNT; i++) begin
            c = {c[CODE_W-KEY_W-1:0], rand_code_key()};
        end
        return c;
    endfunction

    task automatic send_event(t_cmd cmd, logic [KEY_W-1:0] key);
        if (!tx_quiet) begin
            while ($urandom_range(0, 99) < 18) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'h0, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
    endtask

    // hold the input until every outstanding result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_config(logic [CODE_W-1:0] code, logic [IDLE_W-1:0] limit);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_STORED_CODE;
        i_cfg_data <= code;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDLE_LIMIT;
        i_cfg_data <= {{(CODE_W - IDLE_W){1'b0}}, limit};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one full code entry, with erase detours, ticks and ignored keys mixed in
    task automatic enter_code(logic [CODE_W-1:0] code, bit spoil);
        int               bad;
        logic [KEY_W-1:0] nib;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] ignored_keys [3];
        ignored_keys = '{KEY_A, KEY_B, KEY_STAR};
        bad = spoil ? $urandom_range(0, CODE_LENGTH - 1) : -1;
        for (int pos = 0; pos < CODE_LENGTH; pos++) begin
            nib = (pos < NIB_COUNT) ? code[(NIB_COUNT - 1 - pos) * KEY_W +: KEY_W] : KEY_HASH;
            if ($urandom_range(0, 99) < 15) begin
                send_event(CMD_KEY, rand_code_key());
                send_event(CMD_KEY, KEY_ERASE);
            end
            if ($urandom_range(0, 99) < 20) begin
                repeat ($urandom_range(1, 3)) send_event(CMD_TICK, KEY_W'($urandom));
            end
            if ($urandom_range(0, 99) < 5) begin
                send_event(CMD_KEY, ignored_keys[$urandom_range(0, 2)]);
            end
            if (pos == bad) begin
                do k = rand_code_key(); while (k == nib);
            end else begin
                k = nib;
            end
            send_event(CMD_KEY, k);
        end
    endtask

    initial begin : stimulus
        logic [CODE_W-1:0] code;
        int                start;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all-hash code, default idle limit
        send_event(CMD_KEY, KEY_A);
        send_event(CMD_KEY, KEY_B);
        send_event(CMD_KEY, KEY_STAR);
        send_event(CMD_KEY, KEY_ERASE);
        send_event(CMD_KEY, KEY_CANCEL);
        send_event(CMD_TICK, 4'h0);
        send_event(CMD_TICK, 4'hF);
        repeat (CODE_LENGTH) send_event(CMD_KEY, KEY_HASH);
        send_event(CMD_KEY, 4'd0);
        send_event(CMD_KEY, KEY_DIGIT_MAX);
        send_event(CMD_KEY, KEY_ERASE);
        send_event(CMD_KEY, KEY_CANCEL);

        // zero limit: the first tick after any key aborts
        set_config(32'h1234_5F78, 10'd0);
        send_event(CMD_KEY, 4'd5);
        send_event(CMD_TICK, 4'h0);
        send_event(CMD_TICK, 4'h0);
        send_event(CMD_KEY, KEY_ERASE);
        send_event(CMD_TICK, 4'h0);

        // run the idle counter right up to the abort
        tx_quiet = 1'b1;
        set_config(32'h0F0F_0F0F, 10'd20);
        send_event(CMD_KEY, 4'd7);
        repeat (21) send_event(CMD_TICK, 4'h0);
        tx_quiet = 1'b0;

        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       code = 32'h0000_0000;
                4:       code = $urandom;
                7:       code = 32'hFFFF_FFFF;
                8:       code = 32'h9999_9999;
                default: code = rand_valid_code();
            endcase
            set_config(code, IDLE_W'(phase_limits[p]));
            tx_quiet = (p == 3);
            rx_quiet = (p == 3);
            // keep offering events while the sink holds off
            if (p == 2) begin
                rx_hold_req = 1'b1;
            end
            start = n_sent;
            while (n_sent - start < 75) begin
                if ($urandom_range(0, 99) < 55) begin
                    if ($urandom_range(0, 3) != 0) begin
                        send_event(CMD_KEY, KEY_CANCEL);
                    end
                    enter_code(code, $urandom_range(0, 1));
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_event(($urandom_range(0, 99) < 30) ? CMD_TICK : CMD_KEY,
                                   KEY_W'($urandom));
                    end
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("keypad_code_entry_lock regression: pass");
        end else begin
            $display("keypad_code_entry_lock regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kcl_pkg.sv
rtl/kcl_cfg.sv
rtl/kcl_core.sv
rtl/kcl_out.sv
rtl/keypad_code_entry_lock.sv
rtl/kcl_checker.sv
test/keypad_lock_checker.sv
test/tb.sv
